### src/jtss_pkg.sv
package jtss_pkg;

   localparam logic [1:0] KIND_RESET = 2'd0;
   localparam logic [1:0] KIND_IR    = 2'd1;
   localparam logic [1:0] KIND_DR    = 2'd2;
   localparam logic [1:0] KIND_TICK  = 2'd3;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_LEN  = 2'd1;
   localparam logic [1:0] STATUS_BUSY = 2'd2;

   localparam int LEN_W  = 7;
   localparam int DATA_W = 64;

   // classified item as held in the queue between front and back
   typedef struct packed {
      logic [1:0]        kind;
      logic [LEN_W-1:0]  shift_len;
      logic [DATA_W-1:0] shift_data;
      logic              tdo_bit;
      logic              len_ok;
   } jtss_item_type;

   typedef struct packed {
      logic tck_active;
      logic tms;
      logic tdi;
      logic busy_res;
      logic done_res;
      logic [DATA_W-1:0] captured;
      logic [1:0] status;
   } jtss_result_type;

endpackage

### src/jtss_front.sv
module jtss_front import jtss_pkg::*; #(
   parameter int MAX_IR_BITS = 16,
   parameter int MAX_DR_BITS = 64
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [1:0]    req_tuser,
   input  logic [71:0]   req_tdata,
   output logic          item_valid,
   output jtss_item_type item,
   input  logic          item_pop
);

   localparam int DEPTH = 2;

   jtss_item_type entry_ff [DEPTH];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff, count_in;
   jtss_item_type classified;
   logic          push;
   logic          pop;
   logic [LEN_W-1:0] max_len;

   always_comb begin
      classified.kind       = req_tuser;
      classified.shift_len  = req_tdata[6:0];
      classified.shift_data = req_tdata[70:7];
      classified.tdo_bit    = req_tdata[71];
      max_len = (req_tuser == KIND_IR) ? LEN_W'(MAX_IR_BITS) : LEN_W'(MAX_DR_BITS);
      classified.len_ok = (classified.shift_len != '0) && (classified.shift_len <= max_len);
   end

   assign req_tready = (count_ff != 2'(DEPTH));
   assign push       = req_tvalid && req_tready;
   assign item_valid = (count_ff != '0);
   assign pop        = item_pop && item_valid;
   assign item       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

### src/jtss_back.sv
module jtss_back import jtss_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          item_valid,
   input  jtss_item_type item,
   output logic          item_pop,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [71:0]   rsp_tdata
);

   localparam logic [1:0] MODE_IDLE  = 2'd0;
   localparam logic [1:0] MODE_RESET = 2'd1;
   localparam logic [1:0] MODE_IR    = 2'd2;
   localparam logic [1:0] MODE_DR    = 2'd3;

   localparam logic [1:0] PH_PRE  = 2'd0;
   localparam logic [1:0] PH_DATA = 2'd1;
   localparam logic [1:0] PH_POST = 2'd2;

   // TMS patterns, bit 0 goes out first
   localparam logic [7:0]       IR_PRE_PAT  = 8'h06;
   localparam logic [7:0]       DR_PRE_PAT  = 8'h01;
   localparam logic [7:0]       POST_PAT    = 8'h01;
   localparam logic [LEN_W-1:0] RESET_LEN   = 7'd5;
   localparam logic [LEN_W-1:0] IR_PRE_LEN  = 7'd5;
   localparam logic [LEN_W-1:0] DR_PRE_LEN  = 7'd3;
   localparam logic [LEN_W-1:0] POST_LEN    = 7'd2;

   logic [1:0]        mode_ff, mode_in;
   logic [1:0]        phase_ff, phase_in;
   logic [LEN_W-1:0]  step_ff, step_in;
   logic [DATA_W-1:0] shift_ff, shift_in;
   logic [DATA_W-1:0] capture_ff, capture_in;
   logic [LEN_W-1:0]  length_ff, length_in;
   logic              rsp_valid_ff, rsp_valid_in;
   jtss_result_type   rsp_ff;
   jtss_result_type   res;
   logic [LEN_W-1:0]  step_next;
   logic              is_ir;

   assign item_pop  = item_valid && (!rsp_valid_ff || rsp_tready);
   assign step_next = step_ff + 7'd1;
   assign is_ir     = (mode_ff == MODE_IR);

   always_comb begin
      mode_in    = mode_ff;
      phase_in   = phase_ff;
      step_in    = step_ff;
      shift_in   = shift_ff;
      capture_in = capture_ff;
      length_in  = length_ff;
      res        = '0;
      if (item.kind != KIND_TICK) begin
         if (mode_ff != MODE_IDLE) begin
            res.status = STATUS_BUSY;
         end else if (item.kind == KIND_RESET) begin
            mode_in  = MODE_RESET;
            phase_in = PH_PRE;
            step_in  = '0;
         end else if (!item.len_ok) begin
            res.status = STATUS_LEN;
         end else begin
            mode_in    = (item.kind == KIND_IR) ? MODE_IR : MODE_DR;
            phase_in   = PH_PRE;
            step_in    = '0;
            shift_in   = item.shift_data;
            capture_in = '0;
            length_in  = item.shift_len;
         end
      end else if (mode_ff != MODE_IDLE) begin
         res.tck_active = 1'b1;
         step_in = step_next;
         if (mode_ff == MODE_RESET) begin
            res.tms = 1'b1;
            if (step_next >= RESET_LEN) begin
               res.done_res = 1'b1;
               mode_in  = MODE_IDLE;
               phase_in = PH_PRE;
               step_in  = '0;
            end
         end else begin
            case (phase_ff)
               PH_PRE: begin
                  res.tms = is_ir ? IR_PRE_PAT[step_ff[2:0]] : DR_PRE_PAT[step_ff[2:0]];
                  if (step_next >= (is_ir ? IR_PRE_LEN : DR_PRE_LEN)) begin
                     phase_in = PH_DATA;
                     step_in  = '0;
                  end
               end
               PH_DATA: begin
                  // shift register walks right, so bit 0 is always the current TDI
                  res.tdi  = shift_ff[0];
                  shift_in = {1'b0, shift_ff[DATA_W-1:1]};
                  if (!is_ir) begin
                     capture_in[step_ff[5:0]] = item.tdo_bit;
                  end
                  if (step_next >= length_ff) begin
                     res.tms  = 1'b1;
                     phase_in = PH_POST;
                     step_in  = '0;
                  end
               end
               PH_POST: begin
                  res.tms = POST_PAT[step_ff[2:0]];
                  if (step_next >= POST_LEN) begin
                     res.done_res = 1'b1;
                     res.captured = is_ir ? '0 : capture_ff;
                     mode_in  = MODE_IDLE;
                     phase_in = PH_PRE;
                     step_in  = '0;
                  end
               end
               default: begin
                  res.tck_active = 1'b1;
               end
            endcase
         end
      end
      res.busy_res = (mode_in != MODE_IDLE);
   end

   assign rsp_valid_in = item_pop || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         phase_ff     <= PH_PRE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (item_pop) begin
            mode_ff  <= mode_in;
            phase_ff <= phase_in;
            step_ff  <= step_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_pop) begin
         shift_ff   <= shift_in;
         capture_ff <= capture_in;
         length_ff  <= length_in;
         rsp_ff     <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ff.status, rsp_ff.captured, rsp_ff.done_res,
                        rsp_ff.busy_res, rsp_ff.tdi, rsp_ff.tms, rsp_ff.tck_active};

`ifndef NO_ASSERTIONS
   a_done_is_cycle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.done_res |-> rsp_ff.tck_active && !rsp_ff.busy_res)
      else $error("done reported without a TCK cycle or while still busy");

   a_reject_no_cycle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.status != STATUS_OK) |-> !rsp_ff.tck_active && !rsp_ff.tms)
      else $error("rejected command drove a TCK cycle");

   a_capture_on_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.captured != '0) |-> rsp_ff.done_res)
      else $error("captured data shown on a result that does not end a DR shift");

   a_busy_reject: assert property (@(posedge clock) disable iff (reset)
      item_pop && (item.kind != KIND_TICK) && (mode_ff != MODE_IDLE)
      |=> rsp_ff.status == STATUS_BUSY && rsp_ff.busy_res)
      else $error("command while busy not rejected");
`endif

endmodule

### src/jtag_tap_shift_sequencer.sv
// JTAG TAP master sequencer. Commands (TAP reset, shift IR, shift DR) arm a
// sequence; each tick transfer then drives one TCK cycle and returns its TMS
// and TDI levels, taking the TDO bit sampled in that cycle. Every request gives
// exactly one response. One item is taken per clock in steady state while
// responses are accepted: a two-entry queue holds classified requests and the
// sequencer retires one per cycle into the response register. A command sent
// while a sequence runs, or a shift command with a zero or oversized length,
// is rejected in the status field and leaves the sequencer unchanged.
module jtag_tap_shift_sequencer import jtss_pkg::*; #(
   parameter int MAX_IR_BITS = 16,
   parameter int MAX_DR_BITS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // kind
   input  logic [71:0] req_tdata,   // shift_len[6:0], shift_data[70:7], tdo_bit[71]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tck_active[0], tms[1], tdi[2], busy_res[3], done_res[4], captured[68:5],
   // status[70:69], zero[71]
   output logic [71:0] rsp_tdata
);

   logic          item_valid;
   logic          item_pop;
   jtss_item_type item;

   jtss_front #(
      .MAX_IR_BITS (MAX_IR_BITS),
      .MAX_DR_BITS (MAX_DR_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop)
   );

   jtss_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
